// ----- rtl/core/gbts_pkg.sv -----
// ----------------------------------------------------------------------------
// Gap buffer text store package
// Field widths, operation codes and status codes shared by the store.
// ----------------------------------------------------------------------------
package gbts_pkg;

    localparam int OP_W    = 3;
    localparam int CHAR_W  = 8;
    localparam int FIELD_W = 11;
    localparam int STAT_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT    = 3'd0,
        OP_DELETE    = 3'd1,
        OP_BACKSPACE = 3'd2,
        OP_MOVE      = 3'd3,
        OP_READ      = 3'd4
    } op_code_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

endpackage

// ----- rtl/core/gbts_op_if.sv -----
// ----------------------------------------------------------------------------
// Gap buffer operation channel
// Carries one editing operation per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface gbts_op_if;
    import gbts_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [CHAR_W-1:0]  char_in;
    logic [FIELD_W-1:0] position;

    modport source (output valid, output opcode, output char_in, output position,
                    input ready);
    modport sink   (input valid, input opcode, input char_in, input position,
                    output ready);
endinterface

// ----- rtl/core/gbts_res_if.sv -----
// ----------------------------------------------------------------------------
// Gap buffer result channel
// Carries one result per operation with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface gbts_res_if;
    import gbts_pkg::*;

    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [CHAR_W-1:0]  char_out;
    logic [FIELD_W-1:0] text_length;
    logic [FIELD_W-1:0] cursor_pos;

    modport source (output valid, output status, output char_out,
                    output text_length, output cursor_pos, input ready);
    modport sink   (input valid, input status, input char_out,
                    input text_length, input cursor_pos, output ready);
endinterface

// ----- rtl/core/gap_buffer_text_store_unit.sv -----
// ----------------------------------------------------------------------------
// Gap buffer text store
// Byte store with a movable gap at the cursor, held in one synchronous memory.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// op       in         opcode, char_in, position
// res      out        status, char_out, text_length, cursor_pos
//
// Insert, delete, backspace and refused operations finish in the idle state;
// a read waits in S_READ for the registered memory read. A cursor move steps
// through S_MOVE over the distance moved, one memory copy per byte.
// Reset sets the gap to span the whole memory and clears the control state;
// the memory needs no clearing pass. A waiting result holds res and stalls
// op; one item is worked at a time.
module gap_buffer_text_store_unit #(
    parameter int CAPACITY = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    gbts_op_if.sink     op,
    gbts_res_if.source  res
);
    import gbts_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int CW = (PW > FIELD_W) ? PW : FIELD_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MOVE
    } state_t;

    state_t             state_reg, state_next;
    logic [PW-1:0]      gb_reg, gb_next;
    logic [PW-1:0]      gf_reg, gf_next;
    logic [PW-1:0]      cnt_reg, cnt_next;
    logic [AW-1:0]      src_reg, src_next;
    logic [AW-1:0]      dst_reg, dst_next;
    logic               left_reg, left_next;
    logic               pend_reg, pend_next;
    logic               res_valid_reg, res_valid_next;
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic [CHAR_W-1:0]  res_char_reg, res_char_next;
    logic [FIELD_W-1:0] res_len_reg, res_len_next;
    logic [FIELD_W-1:0] res_cur_reg, res_cur_next;

    logic               accept;
    logic               done;
    status_t            status_c;
    logic [CHAR_W-1:0]  char_c;
    logic [PW-1:0]      len_cur;
    logic [PW-1:0]      len_new;
    logic [CW-1:0]      len_cw;
    logic [CW-1:0]      gb_cw;
    logic [CW-1:0]      pos_cw;
    logic [PW-1:0]      pos_pw;
    logic [PW-1:0]      gb_dec;
    logic [PW-1:0]      gf_dec;
    logic [CW-1:0]      addr_cw;
    logic [CW-1:0]      len_new_cw;
    logic [CW-1:0]      gb_new_cw;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [CHAR_W-1:0]  wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [CHAR_W-1:0]  rd_data;

    gbts_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign op.ready        = (state_reg == S_IDLE) && (!res_valid_reg || res.ready);
    assign accept          = op.valid && op.ready;
    assign res.valid       = res_valid_reg;
    assign res.status      = res_status_reg;
    assign res.char_out    = res_char_reg;
    assign res.text_length = res_len_reg;
    assign res.cursor_pos  = res_cur_reg;

    assign len_cur = gb_reg + (PW'(CAPACITY) - gf_reg);
    assign len_cw  = CW'(len_cur);
    assign gb_cw   = CW'(gb_reg);
    assign pos_cw  = CW'(op.position);
    assign pos_pw  = pos_cw[PW-1:0];
    assign gb_dec  = gb_reg - PW'(1);
    assign gf_dec  = gf_reg - PW'(1);
    assign addr_cw = (pos_cw < gb_cw) ? pos_cw : (pos_cw + CW'(gf_reg - gb_reg));

    always_comb
    begin
        state_next      = state_reg;
        gb_next         = gb_reg;
        gf_next         = gf_reg;
        cnt_next        = cnt_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        left_next       = left_reg;
        pend_next       = pend_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_status_next = res_status_reg;
        res_char_next   = res_char_reg;
        res_len_next    = res_len_reg;
        res_cur_next    = res_cur_reg;
        done            = 1'b0;
        status_c        = ST_OK;
        char_c          = '0;
        wr_en           = 1'b0;
        wr_addr         = gb_reg[AW-1:0];
        wr_data         = op.char_in;
        rd_en           = 1'b0;
        rd_addr         = addr_cw[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op_code_t'(op.opcode))
                        OP_INSERT:
                        begin
                            done = 1'b1;
                            if (gb_reg >= gf_reg)
                            begin
                                status_c = ST_FULL;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                gb_next = gb_reg + PW'(1);
                            end
                        end
                        OP_DELETE:
                        begin
                            done = 1'b1;
                            if (gf_reg >= PW'(CAPACITY))
                            begin
                                status_c = ST_EMPTY;
                            end
                            else
                            begin
                                gf_next = gf_reg + PW'(1);
                            end
                        end
                        OP_BACKSPACE:
                        begin
                            done = 1'b1;
                            if (gb_reg == '0)
                            begin
                                status_c = ST_EMPTY;
                            end
                            else
                            begin
                                gb_next = gb_dec;
                            end
                        end
                        OP_MOVE:
                        begin
                            if (pos_cw > len_cw)
                            begin
                                done     = 1'b1;
                                status_c = ST_RANGE;
                            end
                            else if (pos_cw < gb_cw)
                            begin
                                cnt_next   = gb_reg - pos_pw;
                                gb_next    = pos_pw;
                                gf_next    = gf_reg - (gb_reg - pos_pw);
                                src_next   = gb_dec[AW-1:0];
                                dst_next   = gf_dec[AW-1:0];
                                left_next  = 1'b1;
                                pend_next  = 1'b0;
                                state_next = S_MOVE;
                            end
                            else if (pos_cw > gb_cw)
                            begin
                                cnt_next   = pos_pw - gb_reg;
                                gb_next    = pos_pw;
                                gf_next    = gf_reg + (pos_pw - gb_reg);
                                src_next   = gf_reg[AW-1:0];
                                dst_next   = gb_reg[AW-1:0];
                                left_next  = 1'b0;
                                pend_next  = 1'b0;
                                state_next = S_MOVE;
                            end
                            else
                            begin
                                done = 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_cw >= len_cw)
                            begin
                                done     = 1'b1;
                                status_c = ST_RANGE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                done       = 1'b1;
                char_c     = rd_data;
                state_next = S_IDLE;
            end
            S_MOVE:
            begin
                rd_addr   = src_reg;
                wr_addr   = dst_reg;
                wr_data   = rd_data;
                wr_en     = pend_reg;
                pend_next = (cnt_reg != '0);
                if (cnt_reg != '0)
                begin
                    rd_en    = 1'b1;
                    cnt_next = cnt_reg - PW'(1);
                    src_next = left_reg ? (src_reg - AW'(1)) : (src_reg + AW'(1));
                end
                if (pend_reg)
                begin
                    dst_next = left_reg ? (dst_reg - AW'(1)) : (dst_reg + AW'(1));
                end
                if ((cnt_reg == '0) && pend_reg)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        len_new    = gb_next + (PW'(CAPACITY) - gf_next);
        len_new_cw = CW'(len_new);
        gb_new_cw  = CW'(gb_next);
        if (done)
        begin
            res_valid_next  = 1'b1;
            res_status_next = status_c;
            res_char_next   = char_c;
            res_len_next    = len_new_cw[FIELD_W-1:0];
            res_cur_next    = gb_new_cw[FIELD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            gb_reg         <= '0;
            gf_reg         <= PW'(CAPACITY);
            cnt_reg        <= '0;
            src_reg        <= '0;
            dst_reg        <= '0;
            left_reg       <= 1'b0;
            pend_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_status_reg <= '0;
            res_char_reg   <= '0;
            res_len_reg    <= '0;
            res_cur_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            gb_reg         <= gb_next;
            gf_reg         <= gf_next;
            cnt_reg        <= cnt_next;
            src_reg        <= src_next;
            dst_reg        <= dst_next;
            left_reg       <= left_next;
            pend_reg       <= pend_next;
            res_valid_reg  <= res_valid_next;
            res_status_reg <= res_status_next;
            res_char_reg   <= res_char_next;
            res_len_reg    <= res_len_next;
            res_cur_reg    <= res_cur_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
        (gb_reg <= gf_reg) && (gf_reg <= PW'(CAPACITY)))
        else $error("gap pointers out of order");

    a_copy_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("copy read and write hit the same entry");

    a_accept_copy_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ((cnt_reg == '0) || (state_reg != S_MOVE)) && !pend_reg)
        else $error("item accepted while a copy is in flight");

    a_copy_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MOVE) && (cnt_reg == '0) && pend_reg) |=> res_valid_reg)
        else $error("finished move gave no result");
`endif

endmodule

// ----- rtl/core/gbts_mem.sv -----
// ----------------------------------------------------------------------------
// Gap buffer text memory
// Simple dual-port byte memory with one write port and a registered read.
// ----------------------------------------------------------------------------
module gbts_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [gbts_pkg::CHAR_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [gbts_pkg::CHAR_W-1:0] rd_data
);
    import gbts_pkg::*;

    logic [CHAR_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- tb/gap_buffer_text_store_unit_test.sv -----
// ----------------------------------------------------------------------------
// Gap buffer text store testbench
// Drives editing operations through the op channel in bursts with random
// gaps and takes results on a stalling result channel. A mirror of the text,
// the gap and the cursor predicts each result, and every result is checked
// field by field against the oldest prediction. The run covers the empty
// and full buffer, refused operations, long cursor moves and random editing.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_unit_test;
    import gbts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 1024;
    localparam int POS_MAX = 2 ** FIELD_W - 1;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        status_t            status;
        logic [CHAR_W-1:0]  char_out;
        logic [FIELD_W-1:0] text_length;
        logic [FIELD_W-1:0] cursor_pos;
    } edit_outcome_t;

    logic clk;
    logic rst_n;

    gbts_op_if  op_ch ();
    gbts_res_if res_ch ();

    gap_buffer_text_store_unit #(
        .CAPACITY (CAPACITY)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op_ch),
        .res   (res_ch)
    );

    logic [CHAR_W-1:0] text_mirror [CAPACITY];
    int                gap_lo = 0;
    int                gap_hi = CAPACITY;
    edit_outcome_t     pending_outcomes [$];
    int                mismatch_count = 0;
    int                burst_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int text_len();
        return gap_lo + CAPACITY - gap_hi;
    endfunction

    function automatic edit_outcome_t apply_edit(input logic [OP_W-1:0] code,
                                                 input logic [CHAR_W-1:0] ch,
                                                 input logic [FIELD_W-1:0] pos);
        edit_outcome_t r;
        int target;
        r.status = ST_OK;
        r.char_out = '0;
        target = pos;
        case (code)
            OP_INSERT:
                if (gap_lo >= gap_hi)
                    r.status = ST_FULL;
                else
                begin
                    text_mirror[gap_lo] = ch;
                    gap_lo++;
                end
            OP_DELETE:
                if (gap_hi >= CAPACITY)
                    r.status = ST_EMPTY;
                else
                    gap_hi++;
            OP_BACKSPACE:
                if (gap_lo == 0)
                    r.status = ST_EMPTY;
                else
                    gap_lo--;
            OP_MOVE:
                if (target > text_len())
                    r.status = ST_RANGE;
                else
                begin
                    while (gap_lo > target)
                    begin
                        gap_lo--;
                        gap_hi--;
                        text_mirror[gap_hi] = text_mirror[gap_lo];
                    end
                    while (gap_lo < target)
                    begin
                        text_mirror[gap_lo] = text_mirror[gap_hi];
                        gap_lo++;
                        gap_hi++;
                    end
                end
            OP_READ:
                if (target >= text_len())
                    r.status = ST_RANGE;
                else if (target < gap_lo)
                    r.char_out = text_mirror[target];
                else
                    r.char_out = text_mirror[target + gap_hi - gap_lo];
            default: ;
        endcase
        r.text_length = FIELD_W'(text_len());
        r.cursor_pos = FIELD_W'(gap_lo);
        return r;
    endfunction

    task automatic send_op(input logic [OP_W-1:0] code, input logic [CHAR_W-1:0] ch,
                           input logic [FIELD_W-1:0] pos);
        int idle;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(7) == 0) ? 40 : $urandom_range(16, 1);
            idle = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
            if (idle > 0)
            begin
                op_ch.valid <= 1'b0;
                repeat (idle) @(posedge clk);
            end
        end
        burst_left--;
        op_ch.valid    <= 1'b1;
        op_ch.opcode   <= code;
        op_ch.char_in  <= ch;
        op_ch.position <= pos;
        do
            @(posedge clk);
        while (op_ch.ready !== 1'b1);
        pending_outcomes.push_back(apply_edit(code, ch, pos));
    endtask

    task automatic random_edit(input int insert_pct, input int move_pct);
        int pick;
        int len;
        logic [FIELD_W-1:0] pos;
        len = text_len();
        pick = $urandom_range(99);
        pos = FIELD_W'($urandom_range(POS_MAX));
        if (pick < insert_pct)
            send_op(OP_INSERT, CHAR_W'($urandom_range(255)), pos);
        else if (pick < insert_pct + move_pct)
        begin
            if ($urandom_range(9) != 0)
                pos = FIELD_W'($urandom_range(len));
            send_op(OP_MOVE, CHAR_W'($urandom_range(255)), pos);
        end
        else if (pick < insert_pct + move_pct + 20)
        begin
            if (len > 0 && $urandom_range(9) != 0)
                pos = FIELD_W'($urandom_range(len - 1));
            send_op(OP_READ, CHAR_W'($urandom_range(255)), pos);
        end
        else if (pick < 97)
            send_op(($urandom_range(1) == 1) ? OP_DELETE : OP_BACKSPACE,
                    CHAR_W'($urandom_range(255)), pos);
        else
            send_op(OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)),
                    CHAR_W'($urandom_range(255)), pos);
    endtask

    task automatic test_corner_cases();
        send_op(OP_READ, 8'h00, 11'd0);
        send_op(OP_DELETE, 8'h00, 11'd0);
        send_op(OP_BACKSPACE, 8'h00, 11'd0);
        send_op(OP_MOVE, 8'h00, 11'd0);
        send_op(OP_MOVE, 8'h00, 11'd1);
        send_op(OP_INSERT, 8'h00, 11'd0);
        send_op(OP_INSERT, 8'hFF, 11'd0);
        send_op(OP_INSERT, 8'hA5, FIELD_W'(POS_MAX));
        send_op(OP_READ, 8'h00, 11'd0);
        send_op(OP_READ, 8'h00, 11'd2);
        send_op(OP_READ, 8'h00, 11'd3);
        send_op(OP_MOVE, 8'h00, 11'd0);
        send_op(OP_READ, 8'h00, 11'd1);
        send_op(OP_MOVE, 8'h00, 11'd3);
        send_op(OP_MOVE, 8'h00, 11'd4);
        send_op(OP_MOVE, 8'h00, 11'd1);
        send_op(OP_MOVE, 8'h00, 11'd1);
        send_op(OP_READ, 8'h00, 11'd2);
        send_op(OP_DELETE, 8'h00, 11'd0);
        send_op(OP_BACKSPACE, 8'h00, 11'd0);
        send_op(OP_SPARE_LO, 8'hFF, FIELD_W'(POS_MAX));
        send_op(OP_SPARE_HI, 8'h00, 11'd0);
        send_op(OP_READ, 8'h00, FIELD_W'(POS_MAX));
        send_op(OP_MOVE, 8'hFF, FIELD_W'(POS_MAX));
        send_op(OP_READ, 8'h00, 11'd0);
    endtask

    task automatic test_random_edits();
        repeat (250) random_edit(35, 12);
    endtask

    task automatic test_fill_to_capacity();
        int pick;
        while (text_len() < CAPACITY)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                send_op(OP_MOVE, CHAR_W'($urandom_range(255)),
                        FIELD_W'($urandom_range(text_len())));
            else if (pick < 9)
                send_op(OP_READ, CHAR_W'($urandom_range(255)),
                        FIELD_W'($urandom_range(text_len() - 1)));
            else
                send_op(OP_INSERT, CHAR_W'($urandom_range(255)),
                        FIELD_W'($urandom_range(POS_MAX)));
        end
        repeat (3) send_op(OP_INSERT, CHAR_W'($urandom_range(255)),
                           FIELD_W'($urandom_range(POS_MAX)));
        send_op(OP_READ, 8'h00, 11'd0);
        send_op(OP_READ, 8'h00, FIELD_W'(CAPACITY - 1));
        send_op(OP_READ, 8'h00, FIELD_W'(CAPACITY));
        send_op(OP_MOVE, 8'h00, 11'd0);
        send_op(OP_INSERT, 8'h5A, 11'd0);
        send_op(OP_MOVE, 8'h00, FIELD_W'(CAPACITY));
        send_op(OP_DELETE, 8'h00, 11'd0);
        send_op(OP_MOVE, 8'h00, FIELD_W'(CAPACITY + 1));
        send_op(OP_BACKSPACE, 8'h00, 11'd0);
        send_op(OP_INSERT, 8'hC3, 11'd0);
        send_op(OP_READ, 8'h00, FIELD_W'(CAPACITY - 1));
    endtask

    task automatic test_random_removals();
        send_op(OP_MOVE, 8'h00, FIELD_W'($urandom_range(text_len())));
        repeat (150) random_edit(15, 3);
    endtask

    initial
    begin : result_checker
        edit_outcome_t want;
        logic [7:0] stall_mask;
        int stall_span;
        int stall_bit;
        stall_mask = '1;
        stall_span = 0;
        stall_bit = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $display("%0t: result with no operation outstanding", $time);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (res_ch.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, res_ch.status);
                        mismatch_count++;
                    end
                    if (res_ch.char_out !== want.char_out)
                    begin
                        $display("%0t: char_out expected %0h actual %0h",
                                 $time, want.char_out, res_ch.char_out);
                        mismatch_count++;
                    end
                    if (res_ch.text_length !== want.text_length)
                    begin
                        $display("%0t: text_length expected %0d actual %0d",
                                 $time, want.text_length, res_ch.text_length);
                        mismatch_count++;
                    end
                    if (res_ch.cursor_pos !== want.cursor_pos)
                    begin
                        $display("%0t: cursor_pos expected %0d actual %0d",
                                 $time, want.cursor_pos, res_ch.cursor_pos);
                        mismatch_count++;
                    end
                end
            end
            if (stall_span == 0)
            begin
                stall_span = $urandom_range(60, 20);
                stall_mask = ($urandom_range(2) == 0) ? 8'hFF : 8'($urandom_range(255));
            end
            stall_span--;
            stall_bit = (stall_bit + 1) % 8;
            res_ch.ready <= stall_mask[stall_bit];
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        op_ch.valid    <= 1'b0;
        op_ch.opcode   <= OP_INSERT;
        op_ch.char_in  <= '0;
        op_ch.position <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_cases();
        test_random_edits();
        test_fill_to_capacity();
        test_random_removals();

        op_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
